[sv/u8sd_pkg.sv]
package u8sd_pkg;

  localparam int ByteW = 8;
  localparam int CpW   = 21;
  localparam int LenW  = 3;
  localparam int MaxRes = 3;
  localparam int QDepth = MaxRes + 1;

  localparam logic [CpW-1:0] ReplacementCp = CpW'(32'hFFFD);

  // Sequence length announced by a byte in lead position, 0 when it cannot lead.
  function automatic logic [LenW-1:0] lead_length(input logic [ByteW-1:0] b);
    logic [LenW-1:0] len;
    len = '0;
    if (b[7] == 1'b0) begin
      len = LenW'(1);
    end else if (b[7:5] == 3'h6) begin
      len = LenW'(2);
    end else if (b[7:4] == 4'hE) begin
      len = LenW'(3);
    end else if (b[7:3] == 5'h1E) begin
      len = LenW'(4);
    end
    return len;
  endfunction

  function automatic logic [CpW-1:0] assemble(input logic [ByteW-1:0] b0,
                                              input logic [ByteW-1:0] b1,
                                              input logic [ByteW-1:0] b2,
                                              input logic [ByteW-1:0] b3,
                                              input logic [LenW-1:0] len);
    logic [CpW-1:0] cp;
    case (len)
      LenW'(2): cp = {10'b0, b0[4:0], b1[5:0]};
      LenW'(3): cp = {5'b0, b0[3:0], b1[5:0], b2[5:0]};
      LenW'(4): cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default:  cp = ReplacementCp;
    endcase
    return cp;
  endfunction

endpackage

[sv/utf8_stream_decoder_unit.sv]
// UTF-8 byte stream to code point decoder. One byte is taken per cycle while
// s_tready is high, and a byte inside a string gives at most one code point,
// registered into the output queue, so a stream without end marks runs at one
// item per clock while m_tready is high. The byte marked tlast flushes the
// buffered lead and its following bytes and can give up to three code points;
// these sit in a four-entry output queue and leave one per cycle while m_tready
// is high, and the input holds tready low while more than one result is queued.
// Following bytes are not checked; invalid or truncated leads give U+FFFD.
module utf8_stream_decoder_unit
  import u8sd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] data_byte
  input  logic             s_tlast,   // end_of_string
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] zero
  output logic             m_tlast    // last_of_string
);

  typedef struct packed {
    logic           last;
    logic [CpW-1:0] cp;
  } res_t;

  // Buffered lead and following bytes of an incomplete sequence.
  logic [ByteW-1:0] pend [0:2];
  logic [1:0]       pcnt;
  logic [LenW-1:0]  seq_len;

  res_t             q [0:QDepth-1];
  logic [2:0]       rem;

  res_t             nres [0:MaxRes-1];
  logic [1:0]       ncnt;
  logic             hold;
  logic [LenW-1:0]  need;
  logic             push;
  logic             pop;

  res_t             q_next [0:QDepth-1];
  logic [2:0]       rem_next;

  assign s_tready = (rem <= 3'd1);
  assign push     = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (rem != 3'd0);
  assign m_tdata  = {3'b0, q[0].cp};
  assign m_tlast  = q[0].last;

  always_comb begin
    logic [ByteW-1:0] ext [0:7];
    logic [2:0]       n;
    logic [2:0]       i;
    logic [LenW-1:0]  len;
    logic [CpW-1:0]   cp;
    logic [2:0]       adv;

    for (int e = 0; e < 8; e++) begin
      ext[e] = '0;
    end
    for (int e = 0; e < 3; e++) begin
      ext[e] = pend[e];
    end
    ext[{1'b0, pcnt}] = s_tdata;
    n = {1'b0, pcnt} + 3'd1;

    for (int k = 0; k < MaxRes; k++) begin
      nres[k] = '0;
    end
    ncnt = '0;
    hold = 1'b0;
    need = (pcnt == 2'd0) ? lead_length(s_tdata) : seq_len;
    i    = '0;
    len  = '0;
    cp   = '0;
    adv  = '0;

    if (!s_tlast) begin
      if (need == LenW'(0)) begin
        nres[0].cp = ReplacementCp;
        ncnt       = 2'd1;
      end else if (need == LenW'(1)) begin
        nres[0].cp = CpW'(s_tdata);
        ncnt       = 2'd1;
      end else if (n >= need) begin
        nres[0].cp = assemble(ext[0], ext[1], ext[2], ext[3], need);
        ncnt       = 2'd1;
      end else begin
        hold = 1'b1;
      end
    end else begin
      // Decode the buffered bytes plus this one as a whole string; a lead
      // that runs past the end is replaced and decoding resumes after it.
      for (int k = 0; k < MaxRes; k++) begin
        if (i < n) begin
          len = lead_length(ext[i]);
          cp  = ReplacementCp;
          adv = 3'd1;
          if (len == LenW'(1)) begin
            cp = CpW'(ext[i]);
          end else if (len >= LenW'(2) && (4'(i) + 4'(len)) <= 4'(n)) begin
            cp  = assemble(ext[i], ext[i + 3'd1], ext[i + 3'd2], ext[i + 3'd3], len);
            adv = len;
          end
          nres[k].cp = cp;
          ncnt       = 2'(k + 1);
          i          = i + adv;
        end
      end
      for (int k = 0; k < MaxRes; k++) begin
        nres[k].last = (2'(k + 1) == ncnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt    <= '0;
      seq_len <= '0;
    end else if (push) begin
      if (hold) begin
        pend[pcnt] <= s_tdata;
        pcnt       <= pcnt + 2'd1;
        seq_len    <= need;
      end else begin
        pcnt    <= '0;
        seq_len <= '0;
      end
    end
  end

  // Shift queue: the head is always entry 0, new results land after the rest.
  always_comb begin
    logic [2:0] base;
    logic [2:0] off;
    base = rem - {2'b0, pop};
    for (int j = 0; j < QDepth; j++) begin
      q_next[j] = q[j];
      off       = 3'(j) - base;
      if (3'(j) < base) begin
        q_next[j] = q[2'(3'(j) + {2'b0, pop})];
      end else if (push && off < {1'b0, ncnt}) begin
        q_next[j] = nres[2'(off)];
      end
    end
    rem_next = base + (push ? {1'b0, ncnt} : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else begin
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QDepth; j++) begin
      q[j] <= q_next[j];
    end
  end

endmodule
